// File: hw/rtl/adb_keyboard_device_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef ADB_KEYBOARD_DEVICE_CORE_MACROS_SVH
`define ADB_KEYBOARD_DEVICE_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ADBKBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adbkbd: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define ADBKBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adbkbd: next-cycle check failed");

`endif

// File: hw/rtl/adbkbd_pkg.sv
`timescale 1ns / 1ps

package adbkbd_pkg;

  // FIFO geometry
  localparam int FIFO_DEPTH = 128;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Command low nibble codes
  localparam logic [3:0] LO_BUS_RESET = 4'h0;
  localparam logic [3:0] LO_FLUSH     = 4'h1;
  localparam logic [3:0] LO_LISTEN3   = 4'hB;
  localparam logic [3:0] LO_TALK0     = 4'hC;
  localparam logic [3:0] LO_TALK2     = 4'hE;
  localparam logic [3:0] LO_TALK3     = 4'hF;

  // Byte constants
  localparam logic [7:0] PREFIX_BYTE   = 8'hE0;
  localparam logic [7:0] RELEASE_BIT   = 8'h80;
  localparam logic [7:0] CODE_MASK     = 8'h7F;
  localparam logic [7:0] REPLY_FILL    = 8'hFF;
  localparam logic [7:0] LED_FIRST     = 8'h00;
  localparam logic [7:0] LED_SECOND    = 8'h07;
  localparam logic [7:0] HND_KEEP      = 8'hFF;
  localparam logic [7:0] HND_ADDR_A    = 8'hFE;
  localparam logic [7:0] HND_ADDR_B    = 8'hFD;
  localparam logic [7:0] HND_ADDR_C    = 8'h00;
  localparam logic [3:0] RESET_ADDR    = 4'h2;
  localparam logic [7:0] RESET_HANDLER = 8'h01;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_REPLY  = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_DROP   = 2'd3
  } adbkbd_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_POP,
    ST_EMIT
  } adbkbd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic pop;
    logic emit;
  } adbkbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic talk0;
    logic fifo_empty;
    logic head_prefix;
    logic out_free;
  } adbkbd_stat_t;

  // PC scancode to bus key code; unlisted entries map to zero
  function automatic logic [7:0] kbd_xlat(input logic [7:0] idx);
    logic [7:0] v;
    v = 8'd0;
    case (idx)
      8'd1: v = 8'd53;   8'd2: v = 8'd18;   8'd3: v = 8'd19;   8'd4: v = 8'd20;
      8'd5: v = 8'd21;   8'd6: v = 8'd23;   8'd7: v = 8'd22;   8'd8: v = 8'd26;
      8'd9: v = 8'd28;   8'd10: v = 8'd25;  8'd11: v = 8'd29;  8'd12: v = 8'd27;
      8'd13: v = 8'd24;  8'd14: v = 8'd51;  8'd15: v = 8'd48;  8'd16: v = 8'd12;
      8'd17: v = 8'd13;  8'd18: v = 8'd14;  8'd19: v = 8'd15;  8'd20: v = 8'd17;
      8'd21: v = 8'd16;  8'd22: v = 8'd32;  8'd23: v = 8'd34;  8'd24: v = 8'd31;
      8'd25: v = 8'd35;  8'd26: v = 8'd33;  8'd27: v = 8'd30;  8'd28: v = 8'd36;
      8'd29: v = 8'd54;  8'd31: v = 8'd1;   8'd32: v = 8'd2;   8'd33: v = 8'd3;
      8'd34: v = 8'd5;   8'd35: v = 8'd4;   8'd36: v = 8'd38;  8'd37: v = 8'd40;
      8'd38: v = 8'd37;  8'd39: v = 8'd41;  8'd40: v = 8'd39;  8'd41: v = 8'd50;
      8'd42: v = 8'd56;  8'd43: v = 8'd42;  8'd44: v = 8'd6;   8'd45: v = 8'd7;
      8'd46: v = 8'd8;   8'd47: v = 8'd9;   8'd48: v = 8'd11;  8'd49: v = 8'd45;
      8'd50: v = 8'd46;  8'd51: v = 8'd43;  8'd52: v = 8'd47;  8'd53: v = 8'd44;
      8'd54: v = 8'd123; 8'd55: v = 8'd67;  8'd56: v = 8'd58;  8'd57: v = 8'd49;
      8'd58: v = 8'd57;  8'd59: v = 8'd122; 8'd60: v = 8'd120; 8'd61: v = 8'd99;
      8'd62: v = 8'd118; 8'd63: v = 8'd96;  8'd64: v = 8'd97;  8'd65: v = 8'd98;
      8'd66: v = 8'd100; 8'd67: v = 8'd101; 8'd68: v = 8'd109; 8'd69: v = 8'd71;
      8'd70: v = 8'd107; 8'd71: v = 8'd89;  8'd72: v = 8'd91;  8'd73: v = 8'd92;
      8'd74: v = 8'd78;  8'd75: v = 8'd86;  8'd76: v = 8'd87;  8'd77: v = 8'd88;
      8'd78: v = 8'd69;  8'd79: v = 8'd83;  8'd80: v = 8'd84;  8'd81: v = 8'd85;
      8'd82: v = 8'd82;  8'd83: v = 8'd65;  8'd86: v = 8'd10;  8'd87: v = 8'd103;
      8'd88: v = 8'd111; 8'd91: v = 8'd110; 8'd92: v = 8'd81;  8'd131: v = 8'd94;
      8'd133: v = 8'd93; 8'd140: v = 8'd104; 8'd141: v = 8'd102; 8'd156: v = 8'd76;
      8'd157: v = 8'd125; 8'd170: v = 8'd105; 8'd181: v = 8'd75; 8'd184: v = 8'd124;
      8'd199: v = 8'd115; 8'd200: v = 8'd62; 8'd201: v = 8'd116; 8'd203: v = 8'd59;
      8'd205: v = 8'd60; 8'd207: v = 8'd119; 8'd208: v = 8'd61; 8'd209: v = 8'd121;
      8'd210: v = 8'd114; 8'd211: v = 8'd117; 8'd219: v = 8'd55; 8'd220: v = 8'd126;
      8'd222: v = 8'd127; 8'd245: v = 8'd95;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/adbkbd_req_if.sv
`timescale 1ns / 1ps

interface adbkbd_req_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] command_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic [7:0] scancode;

  modport source (
    output valid, command, command_byte, first_data, second_data, scancode,
    input  ready
  );
  modport sink (
    input  valid, command, command_byte, first_data, second_data, scancode,
    output ready
  );
endinterface

// File: hw/rtl/adbkbd_rsp_if.sv
`timescale 1ns / 1ps

interface adbkbd_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] reply_first;
  logic [7:0] reply_second;

  modport source (
    output valid, status, reply_first, reply_second,
    input  ready
  );
  modport sink (
    input  valid, status, reply_first, reply_second,
    output ready
  );
endinterface

// File: hw/rtl/adb_keyboard_device_core.sv
`timescale 1ns / 1ps
// Keyboard device on a serial desktop bus, single device.
// req_i carries one word per item: a key event (command = 0, scancode) or a
// bus command (command_byte plus two listen data bytes). rsp_o returns one
// word per item: status and two reply bytes (zero unless status is a reply).
// Order: a word is taken in the idle state and executed the next cycle;
// the emit step then loads its result into the output register once that
// register is free, and a new word can be taken after that load. Talk
// register 0 walks the key FIFO between execute and emit, reading each
// entry (registered FIFO read, then pop) until it pops a key or the FIFO
// runs dry. The controller handles one word at a time.
// The output register lets the next word enter while a result waits; if
// the receiver stalls, the following result waits in its emit step and
// req_i.ready stays low until the output register frees.
// Reset: FIFO empty, extended flag clear, address 2, handler 1. FIFO
// storage is not cleared; only written entries are ever read.
module adb_keyboard_device_core (
  input logic           clk_i,
  input logic           rst_ni,
  adbkbd_req_if.sink    req_i,
  adbkbd_rsp_if.source  rsp_o
);
  import adbkbd_pkg::*;

  adbkbd_cmd_t  cmd;
  adbkbd_stat_t stat;

  adbkbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  adbkbd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (req_i.command),
    .command_byte_i (req_i.command_byte),
    .first_data_i   (req_i.first_data),
    .second_data_i  (req_i.second_data),
    .scancode_i     (req_i.scancode),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .status_o       (rsp_o.status),
    .reply_first_o  (rsp_o.reply_first),
    .reply_second_o (rsp_o.reply_second)
  );

endmodule

// File: hw/rtl/adbkbd_ctrl.sv
`timescale 1ns / 1ps

module adbkbd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  adbkbd_pkg::adbkbd_stat_t stat_i,
  output adbkbd_pkg::adbkbd_cmd_t  cmd_o
);
  import adbkbd_pkg::*;

  adbkbd_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence one word: capture, execute, walk the FIFO for talk 0, emit
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
        if (req_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.talk0 ? ST_READ : ST_EMIT;
      end
      ST_READ: begin
        state_d = stat_i.fifo_empty ? ST_EMIT : ST_POP;
      end
      ST_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = stat_i.head_prefix ? ST_READ : ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = stat_i.out_free;
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/adbkbd_dp.sv
`timescale 1ns / 1ps

module adbkbd_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adbkbd_pkg::adbkbd_cmd_t  cmd_i,
  output adbkbd_pkg::adbkbd_stat_t stat_o,
  input  logic                     command_i,
  input  logic [7:0]               command_byte_i,
  input  logic [7:0]               first_data_i,
  input  logic [7:0]               second_data_i,
  input  logic [7:0]               scancode_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output logic [1:0]               status_o,
  output logic [7:0]               reply_first_o,
  output logic [7:0]               reply_second_o
);
  import adbkbd_pkg::*;

  // Captured word
  logic       cmd_q;
  logic [7:0] cb_q, d1_q, d2_q, sc_q;

  // Key FIFO
  logic [7:0]       mem_q [FIFO_DEPTH];
  logic [7:0]       rd_data_q;
  logic             mem_we;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  // Device state
  logic       ext_q, ext_d;
  logic [3:0] addr_q, addr_d;
  logic [7:0] hnd_q, hnd_d;

  // Pending result and output register
  logic [1:0] res_status_q, res_status_d;
  logic [7:0] res_r0_q, res_r0_d, res_r1_q, res_r1_d;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q, out_status_d;
  logic [7:0] out_r0_q, out_r0_d, out_r1_q, out_r1_d;

  logic [3:0] lo;
  logic [7:0] xlat_idx;
  logic       fifo_full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign lo        = cb_q[3:0];
  assign fifo_full = (count_q == CNT_W'(FIFO_DEPTH));
  assign xlat_idx  = ext_q ? (rd_data_q | RELEASE_BIT) : (rd_data_q & CODE_MASK);

  // Status toward the controller
  assign stat_o.talk0       = cmd_q && (lo == LO_TALK0) && (cb_q[7:4] == addr_q);
  assign stat_o.fifo_empty  = (count_q == '0);
  assign stat_o.head_prefix = (rd_data_q == PREFIX_BYTE);
  assign stat_o.out_free    = !out_valid_q || rsp_ready_i;

  // Capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      cb_q  <= command_byte_i;
      d1_q  <= first_data_i;
      d2_q  <= second_data_i;
      sc_q  <= scancode_i;
    end
  end

  // FIFO storage: write at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_ptr_q] <= sc_q;
    rd_data_q <= mem_q[rd_ptr_q];
  end

  // Execute the word and pop FIFO entries
  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    count_d      = count_q;
    ext_d        = ext_q;
    addr_d       = addr_q;
    hnd_d        = hnd_q;
    res_status_d = res_status_q;
    res_r0_d     = res_r0_q;
    res_r1_d     = res_r1_q;
    mem_we       = 1'b0;

    if (cmd_i.exec) begin
      res_status_d = STAT_NONE;
      res_r0_d     = 8'h00;
      res_r1_d     = 8'h00;
      priority if (!cmd_q) begin
        if (!fifo_full) begin
          mem_we   = 1'b1;
          wr_ptr_d = ptr_inc(wr_ptr_q);
          count_d  = count_q + 1'b1;
        end else begin
          res_status_d = STAT_DROP;
        end
      end else if (lo == LO_BUS_RESET) begin
        addr_d   = RESET_ADDR;
        hnd_d    = RESET_HANDLER;
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        count_d  = '0;
      end else if (cb_q[7:4] != addr_q) begin
        res_status_d = STAT_ABSENT;
      end else if (lo == LO_FLUSH) begin
        rd_ptr_d = '0;
        wr_ptr_d = '0;
        count_d  = '0;
      end else if (lo == LO_LISTEN3) begin
        if (d2_q == HND_ADDR_A || d2_q == HND_ADDR_B || d2_q == HND_ADDR_C) begin
          addr_d = d1_q[3:0];
        end else if (d2_q != HND_KEEP) begin
          addr_d = d1_q[3:0];
          hnd_d  = d2_q;
        end
      end else if (lo == LO_TALK2) begin
        res_status_d = STAT_REPLY;
        res_r0_d     = LED_FIRST;
        res_r1_d     = LED_SECOND;
      end else if (lo == LO_TALK3) begin
        res_status_d = STAT_REPLY;
        res_r0_d     = hnd_q;
        res_r1_d     = {4'h0, addr_q};
      end else begin
        res_status_d = STAT_NONE;
      end
    end

    // Pop the head: prefixes set the extended flag, others translate
    if (cmd_i.pop) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
      count_d  = count_q - 1'b1;
      if (rd_data_q == PREFIX_BYTE) begin
        ext_d = 1'b1;
      end else begin
        ext_d        = 1'b0;
        res_status_d = STAT_REPLY;
        res_r0_d     = kbd_xlat(xlat_idx) | (rd_data_q & RELEASE_BIT);
        res_r1_d     = REPLY_FILL;
      end
    end
  end

  // Output register: load on emit, drop once taken
  always_comb begin
    out_valid_d  = out_valid_q && !rsp_ready_i;
    out_status_d = out_status_q;
    out_r0_d     = out_r0_q;
    out_r1_d     = out_r1_q;
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_r0_d     = res_r0_q;
      out_r1_d     = res_r1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      count_q     <= '0;
      ext_q       <= 1'b0;
      addr_q      <= RESET_ADDR;
      hnd_q       <= RESET_HANDLER;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      count_q     <= count_d;
      ext_q       <= ext_d;
      addr_q      <= addr_d;
      hnd_q       <= hnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_r0_q     <= res_r0_d;
    res_r1_q     <= res_r1_d;
    out_status_q <= out_status_d;
    out_r0_q     <= out_r0_d;
    out_r1_q     <= out_r1_d;
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign reply_first_o  = out_r0_q;
  assign reply_second_o = out_r1_q;

endmodule

// File: hw/rtl/adbkbd_checker.sv
`timescale 1ns / 1ps
`include "adb_keyboard_device_core_macros.svh"

module adbkbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic [7:0] rsp_reply_first_i,
  input logic [7:0] rsp_reply_second_i
);
  import adbkbd_pkg::*;

  // Hold a stalled result word
  `ADBKBD_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_reply_first_i) && $stable(rsp_reply_second_i))

  // One word in flight: ready drops after each acceptance
  `ADBKBD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // Reply bytes are zero unless the status carries a reply
  `ADBKBD_ASSERT_NOW(a_quiet_reply, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != STAT_REPLY), (rsp_reply_first_i == 8'h00) && (rsp_reply_second_i == 8'h00))

endmodule

bind adb_keyboard_device_core adbkbd_checker u_adbkbd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.status),
  .rsp_reply_first_i  (rsp_o.reply_first),
  .rsp_reply_second_i (rsp_o.reply_second)
);
